// ===== rtl/pau_pkg.sv =====
package pau_pkg;

  localparam int MAX_DEGREE = 20;
  localparam int NCOEF      = MAX_DEGREE + 1;
  localparam int IDX_W      = $clog2(NCOEF);
  localparam int SUM_W      = IDX_W + 1;
  localparam int COEF_W     = 32;

  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_RDC  = 3'd3;
  localparam logic [2:0] CMD_DEG  = 3'd4;

  localparam logic [1:0] STS_OK  = 2'd0;
  localparam logic [1:0] STS_EXP = 2'd1;
  localparam logic [1:0] STS_OVF = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_EXEC,
    DP_START,
    DP_SCAN,
    DP_MUL_CLR,
    DP_MUL,
    DP_MUL_LAST,
    DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  typedef struct packed {
    logic is_deg;
    logic overflow;
  } dp_status_t;

endpackage

// ===== rtl/pau_ctrl.sv =====
module pau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  output logic                out_valid,
  input  logic                out_stall,
  input  pau_pkg::dp_status_t sts,
  output pau_pkg::ctrl_t      ctl
);
  import pau_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             out_valid_next;
  logic             accept, long_cmd, slot_free, cnt_last, load_out;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign long_cmd  = (command == CMD_MUL) || (command == CMD_DEG);
  assign cnt_last  = (cnt == IDX_W'(NCOEF - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && long_cmd) state_next = ST_SCAN;
      ST_SCAN:  if (cnt_last) state_next = ST_CHECK;
      ST_CHECK: state_next = (sts.is_deg || sts.overflow) ? ST_FIN : ST_MUL;
      ST_MUL:   if (cnt_last) state_next = ST_FIN;
      ST_FIN:   if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = DP_NONE;
    ctl.idx  = cnt;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.op   = long_cmd ? DP_START : DP_EXEC;
          load_out = !long_cmd;
        end
      end
      ST_SCAN:  ctl.op = DP_SCAN;
      ST_CHECK: ctl.op = DP_MUL_CLR;
      ST_MUL:   ctl.op = cnt_last ? DP_MUL_LAST : DP_MUL;
      ST_FIN: begin
        if (slot_free) begin
          ctl.op   = DP_FIN;
          load_out = 1'b1;
        end
      end
      default: ctl.op = DP_NONE;
    endcase
  end

  always_comb begin
    if ((state == ST_SCAN) || (state == ST_MUL)) begin
      cnt_next = cnt_last ? '0 : cnt + IDX_W'(1);
    end else begin
      cnt_next = '0;
    end
    if (load_out) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/pau_dp.sv =====
module pau_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  pau_pkg::ctrl_t        ctl,
  output pau_pkg::dp_status_t   sts,
  input  logic [2:0]            command,
  input  logic                  target,
  input  logic signed [31:0]    coefficient,
  input  logic [7:0]            exponent,
  output logic signed [31:0]    value,
  output logic [1:0]            status
);
  import pau_pkg::*;

  logic [COEF_W-1:0] first  [NCOEF];
  logic [COEF_W-1:0] second [NCOEF];
  logic [COEF_W-1:0] acc    [NCOEF];
  logic [COEF_W-1:0] first_next  [NCOEF];
  logic [COEF_W-1:0] second_next [NCOEF];
  logic [COEF_W-1:0] acc_next    [NCOEF];
  logic [COEF_W-1:0] dst_cur [NCOEF];
  logic [COEF_W-1:0] src_cur [NCOEF];
  logic [COEF_W-1:0] dst_nx  [NCOEF];
  logic [COEF_W-1:0] src_nx  [NCOEF];
  logic [COEF_W-1:0] prod    [NCOEF];
  logic [IDX_W-1:0]  deg_dst, deg_dst_next, deg_src, deg_src_next;
  logic              is_deg, is_deg_next, tgt, tgt_next, tsel;
  logic [COEF_W-1:0] value_next;
  logic [1:0]        status_next;
  logic [SUM_W-1:0]  deg_sum;

  assign deg_sum      = {1'b0, deg_dst} + {1'b0, deg_src};
  assign sts.overflow = deg_sum > SUM_W'(MAX_DEGREE);
  assign sts.is_deg   = is_deg;
  assign tsel         = (ctl.op == DP_EXEC) ? target : tgt;

  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      dst_cur[k] = tsel ? second[k] : first[k];
      src_cur[k] = tsel ? first[k]  : second[k];
      prod[k]    = dst_cur[k] * src_cur[0];
    end
  end

  always_comb begin
    dst_nx       = dst_cur;
    src_nx       = src_cur;
    acc_next     = acc;
    deg_dst_next = deg_dst;
    deg_src_next = deg_src;
    is_deg_next  = is_deg;
    tgt_next     = tgt;
    value_next   = value;
    status_next  = status;
    unique case (ctl.op)
      DP_EXEC: begin
        value_next  = '0;
        status_next = STS_OK;
        unique case (command)
          CMD_INIT: begin
            if (exponent > 8'(MAX_DEGREE)) begin
              status_next = STS_EXP;
            end else begin
              for (int k = 0; k < NCOEF; k++) begin
                dst_nx[k] = (exponent == 8'(k)) ? coefficient : '0;
              end
            end
          end
          CMD_ADD: begin
            for (int k = 0; k < NCOEF; k++) begin
              dst_nx[k] = dst_cur[k] + src_cur[k];
            end
          end
          CMD_RDC: begin
            if (exponent <= 8'(MAX_DEGREE)) begin
              value_next = dst_cur[exponent[IDX_W-1:0]];
            end
          end
          default: value_next = '0;
        endcase
      end
      DP_START: begin
        is_deg_next  = (command == CMD_DEG);
        tgt_next     = target;
        deg_dst_next = '0;
        deg_src_next = '0;
      end
      DP_SCAN: begin
        for (int k = 0; k < NCOEF - 1; k++) begin
          dst_nx[k] = dst_cur[k+1];
          src_nx[k] = src_cur[k+1];
        end
        dst_nx[NCOEF-1] = dst_cur[0];
        src_nx[NCOEF-1] = src_cur[0];
        if (dst_cur[0] != '0) deg_dst_next = ctl.idx;
        if (src_cur[0] != '0) deg_src_next = ctl.idx;
      end
      DP_MUL_CLR: begin
        for (int k = 0; k < NCOEF; k++) begin
          acc_next[k] = '0;
        end
      end
      DP_MUL: begin
        for (int k = 0; k < NCOEF; k++) begin
          acc_next[k] = acc[k] + prod[k];
        end
        dst_nx[0] = '0;
        for (int k = 1; k < NCOEF; k++) begin
          dst_nx[k] = dst_cur[k-1];
        end
        for (int k = 0; k < NCOEF - 1; k++) begin
          src_nx[k] = src_cur[k+1];
        end
        src_nx[NCOEF-1] = src_cur[0];
      end
      DP_MUL_LAST: begin
        for (int k = 0; k < NCOEF; k++) begin
          dst_nx[k] = acc[k] + prod[k];
        end
        for (int k = 0; k < NCOEF - 1; k++) begin
          src_nx[k] = src_cur[k+1];
        end
        src_nx[NCOEF-1] = src_cur[0];
      end
      DP_FIN: begin
        value_next  = is_deg ? COEF_W'(deg_dst) : '0;
        status_next = (!is_deg && sts.overflow) ? STS_OVF : STS_OK;
      end
      default: value_next = value;
    endcase
    for (int k = 0; k < NCOEF; k++) begin
      first_next[k]  = tsel ? src_nx[k] : dst_nx[k];
      second_next[k] = tsel ? dst_nx[k] : src_nx[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCOEF; k++) begin
        first[k]  <= '0;
        second[k] <= '0;
      end
    end else begin
      first  <= first_next;
      second <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    acc     <= acc_next;
    deg_dst <= deg_dst_next;
    deg_src <= deg_src_next;
    is_deg  <= is_deg_next;
    tgt     <= tgt_next;
    value   <= value_next;
    status  <= status_next;
  end

endmodule

// ===== rtl/polynomial_arith_unit_core.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_stall   command, target, coefficient, exponent
// out      out_valid / out_stall value, status
//
// Init, add, read coefficient and unused codes: result registered at once.
// Read degree and refused multiply: degree scan over rotating stores, then check and finish states.
// Multiply: the 21-lane multiply row takes one source coefficient per cycle.
// Reset zeroes both coefficient stores directly; no clearing pass.
// in_stall is high while a command runs or while the output register is held.
module polynomial_arith_unit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic               target,
  input  logic signed [31:0] coefficient,
  input  logic [7:0]         exponent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);
  import pau_pkg::*;

  ctrl_t      ctl;
  dp_status_t sts;

  pau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  pau_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .target      (target),
    .coefficient (coefficient),
    .exponent    (exponent),
    .value       (value),
    .status      (status)
  );

endmodule

// ===== rtl/pau_checker.sv =====
module pau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         command,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] value,
  input logic [1:0]         status
);
  import pau_pkg::*;

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("item accepted while result held");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("held result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STS_OK) |-> value == '0)
    else $error("refused item carries nonzero value");

  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command != CMD_MUL && command != CMD_DEG |=> out_valid)
    else $error("single-cycle item gave no result");

  a_long_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_MUL || command == CMD_DEG) |=> in_stall)
    else $error("long item did not block input");

endmodule

bind polynomial_arith_unit_core pau_checker u_pau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .command   (command),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .status    (status)
);
